### rtl/core/apq_pkg.sv
// Shared types, widths and codes for the array max priority queue.
`default_nettype none

package apq_pkg;

   localparam int CAPACITY_DEF = 128;
   localparam int ID_W         = 16;
   localparam int PRIO_W       = 16;
   localparam int STATUS_W     = 2;
   localparam int OCC_W        = 8;

   localparam logic [STATUS_W-1:0] STATUS_DONE  = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd2;

   localparam logic MODE_INSERT = 1'b0;
   localparam logic MODE_REMOVE = 1'b1;

   typedef struct packed {
      logic [ID_W-1:0]          id;
      logic signed [PRIO_W-1:0] prio;
   } entry_type;

   // memory port strobes
   typedef struct packed {
      logic wr_en;
      logic rd_en;
   } store_ctl_type;

   // scan tracker controls
   typedef struct packed {
      logic clear;
      logic hit;
   } scan_ctl_type;

endpackage

`default_nettype wire

### rtl/core/apq_channels_if.sv
// Request and response channel interfaces of the priority queue.
`default_nettype none

interface apq_req_if;
   import apq_pkg::*;
   logic                     valid;
   logic                     ready;
   logic                     mode;
   logic [ID_W-1:0]          entry_id;
   logic signed [PRIO_W-1:0] entry_priority;

   modport source (output valid, output mode, output entry_id, output entry_priority,
                   input ready);
   modport sink   (input valid, input mode, input entry_id, input entry_priority,
                   output ready);
endinterface

interface apq_rsp_if;
   import apq_pkg::*;
   logic                     valid;
   logic                     ready;
   logic [STATUS_W-1:0]      status;
   logic [ID_W-1:0]          removed_id;
   logic signed [PRIO_W-1:0] removed_priority;
   logic [OCC_W-1:0]         occupancy;

   modport source (output valid, output status, output removed_id,
                   output removed_priority, output occupancy, input ready);
   modport sink   (input valid, input status, input removed_id,
                   input removed_priority, input occupancy, output ready);
endinterface

`default_nettype wire

### rtl/core/apq_store.sv
// Entry memory: one write port, one read port, registered read data.
`default_nettype none

module apq_store #(
   parameter int CAPACITY = apq_pkg::CAPACITY_DEF,
   parameter int ADDR_W   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1
) (
   input  logic                   clock,
   input  apq_pkg::store_ctl_type ctl,
   input  logic [ADDR_W-1:0]      wr_addr,
   input  apq_pkg::entry_type     wr_data,
   input  logic [ADDR_W-1:0]      rd_addr,
   output apq_pkg::entry_type     rd_data
);
   import apq_pkg::*;

   entry_type mem [CAPACITY];
   entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (ctl.wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (ctl.rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

### rtl/core/apq_scan.sv
// Running maximum tracker for the removal scan; also keeps the last entry read.
`default_nettype none

module apq_scan #(
   parameter int ADDR_W = (apq_pkg::CAPACITY_DEF > 1) ? $clog2(apq_pkg::CAPACITY_DEF) : 1
) (
   input  logic                  clock,
   input  logic                  reset,
   input  apq_pkg::scan_ctl_type ctl,
   input  logic [ADDR_W-1:0]     hit_idx,
   input  apq_pkg::entry_type    hit_data,
   output apq_pkg::entry_type    best,
   output logic [ADDR_W-1:0]     best_idx,
   output apq_pkg::entry_type    last
);
   import apq_pkg::*;

   logic              first_ff;
   logic              first_in;
   entry_type         best_ff;
   entry_type         best_in;
   logic [ADDR_W-1:0] best_idx_ff;
   logic [ADDR_W-1:0] best_idx_in;
   entry_type         last_ff;
   entry_type         last_in;
   logic              take;

   // strictly greater keeps the lowest slot on ties
   assign take = first_ff || ($signed(hit_data.prio) > $signed(best_ff.prio));

   always_comb begin
      first_in    = first_ff;
      best_in     = best_ff;
      best_idx_in = best_idx_ff;
      last_in     = last_ff;
      if (ctl.clear) begin
         first_in = 1'b1;
      end else if (ctl.hit) begin
         first_in = 1'b0;
         last_in  = hit_data;
         if (take) begin
            best_in     = hit_data;
            best_idx_in = hit_idx;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         first_ff <= 1'b1;
      end else begin
         first_ff <= first_in;
      end
   end

   always_ff @(posedge clock) begin
      best_ff     <= best_in;
      best_idx_ff <= best_idx_in;
      last_ff     <= last_in;
   end

   assign best     = best_ff;
   assign best_idx = best_idx_ff;
   assign last     = last_ff;

endmodule

`default_nettype wire

### rtl/core/array_max_priority_queue_unit.sv
// Top level of the unsorted-array max priority queue.
//
//   channel  | dir | handshake          | payload
//   ---------+-----+--------------------+----------------------------------------------
//   req_ch   | in  | valid/ready        | mode, entry_id, entry_priority
//   rsp_ch   | out | valid/ready        | status, removed_id, removed_priority, occupancy
//
// Insert: the result is loaded into the output register at acceptance.
// Remove: one memory read per stored entry on the single read port, then one
//   write that moves the last entry into the freed slot.
// Remove on an empty store: the EMPTY result is loaded at acceptance.
// One item at a time; req_ch.ready is held low while a removal scans, and while
//   the output register holds a result the sink has not taken.
// Synchronous reset clears the count, the state and the output valid; the
//   memory contents stay undefined and are only read below the count.
`default_nettype none

module array_max_priority_queue_unit #(
   parameter int CAPACITY = apq_pkg::CAPACITY_DEF
) (
   input  logic     clock,
   input  logic     reset,
   apq_req_if.sink  req_ch,
   apq_rsp_if.source rsp_ch
);
   import apq_pkg::*;

   localparam int ADDR_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CNT_W  = $clog2(CAPACITY + 1);

   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_SCAN   = 2'd1;
   localparam logic [1:0] ST_FINISH = 2'd2;

   logic [1:0]        state_ff;
   logic [1:0]        state_in;
   logic [CNT_W-1:0]  count_ff;
   logic [CNT_W-1:0]  count_in;
   logic [CNT_W-1:0]  idx_ff;       // next slot to read during a scan
   logic [CNT_W-1:0]  idx_in;
   logic              hit_ff;       // read data returns this cycle
   logic [ADDR_W-1:0] hit_idx_ff;

   // output register
   logic                     rsp_valid_ff;
   logic                     rsp_valid_in;
   logic [STATUS_W-1:0]      rsp_status_ff;
   logic [STATUS_W-1:0]      rsp_status_in;
   entry_type                rsp_entry_ff;
   entry_type                rsp_entry_in;
   logic [OCC_W-1:0]         rsp_occ_ff;
   logic [OCC_W-1:0]         rsp_occ_in;

   store_ctl_type     store_ctl;
   logic [ADDR_W-1:0] wr_addr;
   entry_type         wr_data;
   logic [ADDR_W-1:0] rd_addr;
   entry_type         rd_data;

   scan_ctl_type      scan_ctl;
   entry_type         best;
   logic [ADDR_W-1:0] best_idx;
   entry_type         last;

   logic out_free;
   logic accept;

   assign out_free     = !rsp_valid_ff || rsp_ch.ready;
   assign req_ch.ready = (state_ff == ST_IDLE) && out_free;
   assign accept       = req_ch.valid && req_ch.ready;

   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      idx_in        = idx_ff;
      store_ctl     = '0;
      wr_addr       = count_ff[ADDR_W-1:0];
      wr_data.id    = req_ch.entry_id;
      wr_data.prio  = req_ch.entry_priority;
      rd_addr       = idx_ff[ADDR_W-1:0];
      scan_ctl.clear = 1'b0;
      scan_ctl.hit   = hit_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ch.ready;
      rsp_status_in = rsp_status_ff;
      rsp_entry_in  = rsp_entry_ff;
      rsp_occ_in    = rsp_occ_ff;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_ch.mode == MODE_INSERT) begin
                  rsp_valid_in  = 1'b1;
                  rsp_entry_in  = '0;
                  if (count_ff >= CNT_W'(CAPACITY)) begin
                     rsp_status_in = STATUS_FULL;
                     rsp_occ_in    = OCC_W'(count_ff);
                  end else begin
                     store_ctl.wr_en = 1'b1;
                     count_in        = count_ff + CNT_W'(1);
                     rsp_status_in   = STATUS_DONE;
                     rsp_occ_in      = OCC_W'(count_in);
                  end
               end else if (count_ff == '0) begin
                  rsp_valid_in  = 1'b1;
                  rsp_entry_in  = '0;
                  rsp_status_in = STATUS_EMPTY;
                  rsp_occ_in    = '0;
               end else begin
                  scan_ctl.clear = 1'b1;
                  idx_in         = '0;
                  state_in       = ST_SCAN;
               end
            end
         end
         ST_SCAN: begin
            if (idx_ff < count_ff) begin
               store_ctl.rd_en = 1'b1;
               idx_in          = idx_ff + CNT_W'(1);
            end else if (!hit_ff) begin
               // last compare has landed in the tracker
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (out_free) begin
               // move the last entry into the slot being vacated
               store_ctl.wr_en = 1'b1;
               wr_addr         = best_idx;
               wr_data         = last;
               count_in        = count_ff - CNT_W'(1);
               rsp_valid_in    = 1'b1;
               rsp_status_in   = STATUS_DONE;
               rsp_entry_in    = best;
               rsp_occ_in      = OCC_W'(count_in);
               state_in        = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         hit_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         hit_ff       <= store_ctl.rd_en;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff        <= idx_in;
      hit_idx_ff    <= idx_ff[ADDR_W-1:0];
      rsp_status_ff <= rsp_status_in;
      rsp_entry_ff  <= rsp_entry_in;
      rsp_occ_ff    <= rsp_occ_in;
   end

   apq_store #(
      .CAPACITY (CAPACITY),
      .ADDR_W   (ADDR_W)
   ) u_store (
      .clock   (clock),
      .ctl     (store_ctl),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   apq_scan #(
      .ADDR_W (ADDR_W)
   ) u_scan (
      .clock    (clock),
      .reset    (reset),
      .ctl      (scan_ctl),
      .hit_idx  (hit_idx_ff),
      .hit_data (rd_data),
      .best     (best),
      .best_idx (best_idx),
      .last     (last)
   );

   assign rsp_ch.valid            = rsp_valid_ff;
   assign rsp_ch.status           = rsp_status_ff;
   assign rsp_ch.removed_id       = rsp_entry_ff.id;
   assign rsp_ch.removed_priority = rsp_entry_ff.prio;
   assign rsp_ch.occupancy        = rsp_occ_ff;

endmodule

`default_nettype wire

### bench/array_max_priority_queue_unit_tb.sv
// Self-checking testbench for the unsorted-array max priority queue.
`default_nettype none

module array_max_priority_queue_unit_tb;
   import apq_pkg::*;

   localparam int          CAPACITY    = CAPACITY_DEF;
   localparam int          SEGMENTS    = 17;      // random part: 17 x 100 items
   localparam int          SEG_ITEMS   = 100;
   localparam int unsigned CYCLE_LIMIT = 2_000_000;
   localparam int unsigned HOLD_AFTER  = 700;     // results taken before the long hold-off
   localparam int unsigned HOLD_CYCLES = 400;
   localparam int          REPORT_MAX  = 10;

   // One result item, as the response channel carries it.
   typedef struct packed {
      logic [STATUS_W-1:0]      status;
      logic [ID_W-1:0]          id;
      logic signed [PRIO_W-1:0] prio;
      logic [OCC_W-1:0]         occupancy;
   } queue_result_type;

   // Keeps its own copy of the queue, predicts each result and checks the
   // results in order against the predictions.
   class max_queue_checker;
      entry_type        slots[CAPACITY];
      int unsigned      stored;
      queue_result_type awaited_results[$];
      int unsigned      mismatch_count;
      int unsigned      checked_count;

      function new();
         stored         = 0;
         mismatch_count = 0;
         checked_count  = 0;
      endfunction

      // An accepted request: update the model and queue its result.
      function void note_request(logic mode, logic [ID_W-1:0] id,
                                 logic signed [PRIO_W-1:0] prio);
         queue_result_type r;
         int unsigned      best;
         r.status = STATUS_DONE;
         r.id     = '0;
         r.prio   = '0;
         if (mode == MODE_INSERT) begin
            if (stored >= CAPACITY) begin
               r.status = STATUS_FULL;
            end else begin
               slots[stored].id   = id;
               slots[stored].prio = prio;
               stored++;
            end
         end else if (stored == 0) begin
            r.status = STATUS_EMPTY;
         end else begin
            // first slot with the strictly highest priority wins
            best = 0;
            for (int unsigned i = 1; i < stored; i++) begin
               if ($signed(slots[i].prio) > $signed(slots[best].prio)) best = i;
            end
            r.id        = slots[best].id;
            r.prio      = slots[best].prio;
            slots[best] = slots[stored - 1];
            stored--;
         end
         r.occupancy = OCC_W'(stored);
         awaited_results.push_back(r);
      endfunction

      function void check_result(queue_result_type got);
         queue_result_type want;
         checked_count++;
         if (awaited_results.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= REPORT_MAX)
               $display("result with nothing awaited: status %0d id %h prio %0d occ %0d",
                        got.status, got.id, got.prio, got.occupancy);
            return;
         end
         want = awaited_results.pop_front();
         if (got.status !== want.status || got.id !== want.id ||
             got.prio !== want.prio || got.occupancy !== want.occupancy) begin
            mismatch_count++;
            if (mismatch_count <= REPORT_MAX)
               $display("result %0d: expected status %0d id %h prio %0d occ %0d,",
                        checked_count, want.status, want.id, want.prio, want.occupancy,
                        " got status %0d id %h prio %0d occ %0d",
                        got.status, got.id, got.prio, got.occupancy);
         end
      endfunction

      function int unsigned pending();
         return awaited_results.size();
      endfunction
   endclass

   logic        clock;
   logic        reset;
   int unsigned cycle_count;
   int unsigned req_idle_pct;    // chance per cycle that the sender stays idle
   int unsigned rsp_stall_pct;   // chance per cycle that the receiver stalls

   max_queue_checker sb = new();

   apq_req_if req_ch ();
   apq_rsp_if rsp_ch ();

   array_max_priority_queue_unit #(
      .CAPACITY (CAPACITY)
   ) dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   // 8-unit clock period
   initial clock = 1'b0;
   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Everything the block sees is known from time zero.
   initial begin
      reset                 = 1'b1;
      req_ch.valid          = 1'b0;
      req_ch.mode           = MODE_INSERT;
      req_ch.entry_id       = '0;
      req_ch.entry_priority = '0;
      rsp_ch.ready          = 1'b0;
      req_idle_pct          = 0;
      rsp_stall_pct         = 0;
   end

   // Watchdog: a generous bound over the slowest legal run.
   initial cycle_count = 0;
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("array_max_priority_queue_unit_tb failed");
         $finish;
      end
   end

   // Result monitor: sample on the rising edge, before the block updates.
   always @(posedge clock) begin
      queue_result_type got;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         got.status    = rsp_ch.status;
         got.id        = rsp_ch.removed_id;
         got.prio      = rsp_ch.removed_priority;
         got.occupancy = rsp_ch.occupancy;
         sb.check_result(got);
      end
   end

   // Receiver: random stalls per the current idling phase, plus one long
   // hold-off so that the block backs up and holds its input off.
   initial begin : rsp_driver
      int unsigned hold_left;
      bit          hold_done;
      hold_left = 0;
      hold_done = 0;
      forever begin
         @(negedge clock);
         if (!hold_done && sb.checked_count >= HOLD_AFTER) begin
            hold_done = 1;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left != 0) begin
            hold_left--;
            rsp_ch.ready <= 1'b0;
         end else begin
            rsp_ch.ready <= ($urandom_range(99) >= rsp_stall_pct);
         end
      end
   end

   // Offer one item; entered and left at a falling edge. Valid only drops
   // when the sender idles, so back-to-back items keep it high.
   task automatic send_request(input logic mode, input logic [ID_W-1:0] id,
                               input logic signed [PRIO_W-1:0] prio);
      while ($urandom_range(99) < req_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(negedge clock);
      end
      req_ch.valid          <= 1'b1;
      req_ch.mode           <= mode;
      req_ch.entry_id       <= id;
      req_ch.entry_priority <= prio;
      do @(posedge clock); while (!req_ch.ready);
      sb.note_request(mode, id, prio);
      @(negedge clock);
   endtask

   // Sender pause: nothing offered until every awaited result is in.
   task automatic wait_for_drain();
      req_ch.valid <= 1'b0;
      do @(negedge clock); while (sb.pending() != 0);
   endtask

   // Mix of full-range values, a narrow band that forces ties, and extremes.
   function automatic logic signed [PRIO_W-1:0] pick_priority();
      int unsigned sel;
      sel = $urandom_range(9);
      if (sel <= 4) return PRIO_W'($urandom);
      if (sel <= 7) return PRIO_W'($signed($urandom_range(8)) - 4);
      case ($urandom_range(3))
         0:       return 16'sh8000;
         1:       return 16'sh7FFF;
         2:       return -16'sd1;
         default: return 16'sd0;
      endcase
   endfunction

   initial begin : stimulus
      int unsigned insert_pct;
      logic        mode;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // ---- directed part, no idling ----
      // removal from an empty store
      send_request(MODE_REMOVE, 16'h1111, 16'sd7);
      // extremes of id and priority, with a tie at the top
      send_request(MODE_INSERT, 16'h0000, 16'sh8000);
      send_request(MODE_INSERT, 16'hFFFF, 16'sh7FFF);
      send_request(MODE_INSERT, 16'h1234, 16'sh7FFF);
      send_request(MODE_INSERT, 16'hABCD, 16'sd0);
      send_request(MODE_INSERT, 16'h5555, -16'sd1);
      // tie goes to the lower slot; each removal moves the last entry down
      repeat (5) send_request(MODE_REMOVE, 16'hFFFF, 16'sh7FFF);
      send_request(MODE_REMOVE, 16'h0000, 16'sd0);
      // three equal priorities and one lower one; removals move entries into freed slots
      send_request(MODE_INSERT, 16'h00A1, 16'sd5);
      send_request(MODE_INSERT, 16'h00A2, 16'sd5);
      send_request(MODE_INSERT, 16'h00A3, 16'sd5);
      send_request(MODE_INSERT, 16'h00A4, -16'sd5);
      repeat (4) send_request(MODE_REMOVE, 16'h0000, 16'sd0);
      wait_for_drain();

      // ---- random part ----
      // Segments cycle the idling phase and the insert/remove balance. Two
      // insert-heavy segments in a row drive the store to full; two
      // remove-heavy ones bring it back to empty.
      for (int seg = 0; seg < SEGMENTS; seg++) begin
         case (seg % 4)
            0:       begin req_idle_pct = 0;  rsp_stall_pct = 0;  end
            1:       begin req_idle_pct = 68; rsp_stall_pct = 0;  end
            2:       begin req_idle_pct = 0;  rsp_stall_pct = 68; end
            default: begin req_idle_pct = 12; rsp_stall_pct = 12; end
         endcase
         case (seg % 6)
            0, 1:    insert_pct = 90;
            3, 4:    insert_pct = 12;
            default: insert_pct = 50;
         endcase
         if (seg == SEGMENTS / 2) wait_for_drain();
         for (int n = 0; n < SEG_ITEMS; n++) begin
            mode = ($urandom_range(99) < insert_pct) ? MODE_INSERT : MODE_REMOVE;
            send_request(mode, ID_W'($urandom), pick_priority());
         end
      end
      req_ch.valid <= 1'b0;

      // let every result come back, then allow for one full scan of slack
      while (sb.pending() != 0) @(posedge clock);
      repeat (CAPACITY + 8) @(posedge clock);

      if (sb.mismatch_count == 0 && sb.pending() == 0) begin
         $display("array_max_priority_queue_unit_tb passed");
      end else begin
         $display("array_max_priority_queue_unit_tb failed");
      end
      $finish;
   end

endmodule

`default_nettype wire

### filelist.f
rtl/core/apq_pkg.sv
rtl/core/apq_channels_if.sv
rtl/core/apq_store.sv
rtl/core/apq_scan.sv
rtl/core/array_max_priority_queue_unit.sv
bench/array_max_priority_queue_unit_tb.sv
